FILE: rtl/core/hmc_pkg.sv
// ----------------------------------------------------------------------------
// hmc_pkg: shared types and constants of the hashed memo cache
// Request and response layouts, table entry layout and hash constants.
// ----------------------------------------------------------------------------
package hmc_pkg;

  localparam int unsigned HMC_INDEX_BITS = 10;
  localparam int unsigned ID_W           = 63;
  localparam int unsigned EXP_W          = 6;

  // Request operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  // Hash constants, all in 64-bit wrapping arithmetic.
  localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2    = 64'h94d049bb133111eb;
  localparam logic [63:0] HASH_SEED = 64'h243f6a8885a308d3;

  // Word k (from 0) enters the mixer as w + (k + 2) * GOLDEN: the word
  // offset plus the mixer's own golden-ratio increment.
  localparam logic [63:0] WORD_OFS0 = 64'(GOLDEN * 64'd2);
  localparam logic [63:0] WORD_OFS1 = 64'(GOLDEN * 64'd3);
  localparam logic [63:0] WORD_OFS2 = 64'(GOLDEN * 64'd4);
  localparam logic [63:0] WORD_OFS3 = 64'(GOLDEN * 64'd5);

  typedef struct packed {
    logic             operation;
    logic [ID_W-1:0]  from_id;
    logic [EXP_W-1:0] step_exp;
    logic [ID_W-1:0]  to_id;
  } hmc_req_t;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] result_id;
  } hmc_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  key_id;
    logic [EXP_W-1:0] key_exp;
    logic [ID_W-1:0]  result;
  } hmc_entry_t;

  function automatic logic [63:0] word_offset(input logic [1:0] k);
    logic [63:0] ofs;
    unique case (k)
      2'd0:    ofs = WORD_OFS0;
      2'd1:    ofs = WORD_OFS1;
      2'd2:    ofs = WORD_OFS2;
      default: ofs = WORD_OFS3;
    endcase
    return ofs;
  endfunction

endpackage

FILE: rtl/core/hmc_front.sv
// ----------------------------------------------------------------------------
// hmc_front: request intake and iterative key hash
// Takes one request, hashes its key with one shared 32x32 multiplier and
// hands the request with its table index to the request queue.
// ----------------------------------------------------------------------------
module hmc_front #(
  parameter int unsigned INDEX_BITS = hmc_pkg::HMC_INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  input  hmc_pkg::hmc_req_t      req_in,
  output logic                   idle,
  output logic                   q_push,
  input  logic                   q_full,
  output hmc_pkg::hmc_req_t      q_req,
  output logic [INDEX_BITS-1:0]  q_index
);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_PREP = 6'b000010,
    F_MUL1 = 6'b000100,
    F_MUL2 = 6'b001000,
    F_MULG = 6'b010000,
    F_PUSH = 6'b100000
  } front_state_t;

  localparam logic [1:0] PH_LAST  = 2'd3;
  localparam logic [1:0] WORD_END = 2'd3;

  front_state_t          state_r, state_nxt;
  hmc_pkg::hmc_req_t     req_r, req_nxt;
  logic [63:0]           h_r, h_nxt;
  logic [63:0]           mul_a_r, mul_a_nxt;
  logic [63:0]           acc_r, acc_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [1:0]            word_r, word_nxt;
  logic                  final_r, final_nxt;
  logic [INDEX_BITS-1:0] index_r, index_nxt;

  logic [63:0] mul_const;
  logic [31:0] op_a, op_c;
  logic [63:0] prod;
  logic [63:0] word_val, word_in, mixed_out, h_mixed, h_mul, fin_in;
  logic        in_mul;

  // One 32x32 multiplier; a 64-bit wrapping product takes three passes.
  always_comb begin
    unique case (state_r)
      F_MUL1:  mul_const = hmc_pkg::MIX_C1;
      F_MUL2:  mul_const = hmc_pkg::MIX_C2;
      default: mul_const = hmc_pkg::GOLDEN;
    endcase
  end

  assign op_a   = (phase_r == 2'd2) ? mul_a_r[63:32] : mul_a_r[31:0];
  assign op_c   = (phase_r == 2'd1) ? mul_const[63:32] : mul_const[31:0];
  assign prod   = {32'b0, op_a} * {32'b0, op_c};
  assign in_mul = (state_r == F_MUL1) || (state_r == F_MUL2) || (state_r == F_MULG);

  assign word_val  = word_r[0] ? {58'b0, req_r.step_exp} : {1'b0, req_r.from_id};
  assign word_in   = word_val + hmc_pkg::word_offset(word_r);
  assign mixed_out = acc_r ^ (acc_r >> 31);
  assign h_mixed   = h_r ^ mixed_out;
  assign h_mul     = acc_r ^ (mul_a_r >> 32);
  assign fin_in    = h_mul + hmc_pkg::GOLDEN;

  always_comb begin
    acc_nxt = acc_r;
    if (in_mul) begin
      if (phase_r == 2'd0) begin
        acc_nxt = prod;
      end else if (phase_r != PH_LAST) begin
        acc_nxt = acc_r + {prod[31:0], 32'b0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    h_nxt     = h_r;
    mul_a_nxt = mul_a_r;
    phase_nxt = phase_r;
    word_nxt  = word_r;
    final_nxt = final_r;
    index_nxt = index_r;
    q_push    = 1'b0;
    if (in_mul && phase_r != PH_LAST) begin
      phase_nxt = phase_r + 2'd1;
    end
    unique case (state_r)
      F_IDLE: begin
        if (req_valid) begin
          req_nxt   = req_in;
          h_nxt     = hmc_pkg::HASH_SEED;
          word_nxt  = 2'd0;
          final_nxt = 1'b0;
          state_nxt = F_PREP;
        end
      end
      F_PREP: begin
        mul_a_nxt = word_in ^ (word_in >> 30);
        phase_nxt = 2'd0;
        state_nxt = F_MUL1;
      end
      F_MUL1: begin
        if (phase_r == PH_LAST) begin
          mul_a_nxt = acc_r ^ (acc_r >> 27);
          phase_nxt = 2'd0;
          state_nxt = F_MUL2;
        end
      end
      F_MUL2: begin
        if (phase_r == PH_LAST) begin
          phase_nxt = 2'd0;
          if (final_r) begin
            index_nxt = mixed_out[INDEX_BITS-1:0];
            state_nxt = F_PUSH;
          end else begin
            h_nxt     = h_mixed;
            mul_a_nxt = h_mixed;
            state_nxt = F_MULG;
          end
        end
      end
      F_MULG: begin
        if (phase_r == PH_LAST) begin
          h_nxt     = h_mul;
          phase_nxt = 2'd0;
          if (word_r == WORD_END) begin
            final_nxt = 1'b1;
            mul_a_nxt = fin_in ^ (fin_in >> 30);
            state_nxt = F_MUL1;
          end else begin
            word_nxt  = word_r + 2'd1;
            state_nxt = F_PREP;
          end
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      phase_r <= 2'd0;
      word_r  <= 2'd0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      word_r  <= word_nxt;
      final_r <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    h_r     <= h_nxt;
    mul_a_r <= mul_a_nxt;
    acc_r   <= acc_nxt;
    index_r <= index_nxt;
  end

  assign idle    = (state_r == F_IDLE);
  assign q_req   = req_r;
  assign q_index = index_r;

  // The index is only handed on after the final mixing round.
  a_push_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == F_PUSH) |-> $past(final_r))
    else $error("front reached push without the final mixing round");

endmodule

FILE: rtl/core/hmc_queue.sv
// ----------------------------------------------------------------------------
// hmc_queue: two-entry request queue
// Decouples the hash front from the table back end.
// ----------------------------------------------------------------------------
module hmc_queue #(
  parameter int unsigned WIDTH = $bits(hmc_pkg::hmc_req_t) + hmc_pkg::HMC_INDEX_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_push,
  output logic             q_full,
  input  logic [WIDTH-1:0] q_wdata,
  input  logic             q_pop,
  output logic             q_empty,
  output logic [WIDTH-1:0] q_rdata
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_rdata = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (q_pop && !q_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

FILE: rtl/core/hmc_back.sv
// ----------------------------------------------------------------------------
// hmc_back: memo table and response register
// Clears the table after reset, then carries out stores and lookups one
// request at a time and holds each response until it is taken.
// ----------------------------------------------------------------------------
module hmc_back #(
  parameter int unsigned INDEX_BITS = hmc_pkg::HMC_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  hmc_pkg::hmc_req_t     q_req,
  input  logic [INDEX_BITS-1:0] q_index,
  output logic                  clearing,
  output logic                  out_empty,
  input  logic                  out_pop,
  output hmc_pkg::hmc_rsp_t     out_rsp
);

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_LOOK  = 3'b100
  } back_state_t;

  back_state_t                  state_r, state_nxt;
  logic [INDEX_BITS-1:0]        clr_cnt_r;
  logic                         out_valid_r, out_valid_nxt;
  hmc_pkg::hmc_rsp_t            out_rsp_r, out_rsp_nxt;
  logic [hmc_pkg::ID_W-1:0]     key_id_r;
  logic [hmc_pkg::EXP_W-1:0]    key_exp_r;

  hmc_pkg::hmc_entry_t          mem [DEPTH];
  hmc_pkg::hmc_entry_t          rd_data_r;
  hmc_pkg::hmc_entry_t          wr_data;
  logic [INDEX_BITS-1:0]        wr_addr;
  logic                         wr_en, rd_en, take, is_store, match;

  assign clearing = (state_r == B_CLEAR);
  assign take     = (state_r == B_IDLE) && !q_empty && (!out_valid_r || out_pop);
  assign q_pop    = take;
  assign is_store = (q_req.operation == hmc_pkg::OP_STORE);

  assign wr_en   = clearing || (take && is_store);
  assign rd_en   = take && !is_store;
  assign wr_addr = clearing ? clr_cnt_r : q_index;
  assign wr_data = clearing ? '0 :
                   {1'b1, q_req.from_id, q_req.step_exp, q_req.to_id};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[q_index];
    end
  end

  assign match = rd_data_r.valid && (rd_data_r.key_id == key_id_r) &&
                 (rd_data_r.key_exp == key_exp_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_rsp_nxt   = out_rsp_r;
    unique case (state_r)
      B_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (take) begin
          if (is_store) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
          end else begin
            state_nxt = B_LOOK;
          end
        end
      end
      B_LOOK: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = match ? {1'b1, rd_data_r.result} : '0;
        state_nxt     = B_IDLE;
      end
      default: begin
        state_nxt = B_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    if (take) begin
      key_id_r  <= q_req.from_id;
      key_exp_r <= q_req.step_exp;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!out_valid_r && !q_pop))
    else $error("request handled during table clearing");

  a_look_responds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LOOK) |=> out_valid_r)
    else $error("lookup finished without a response");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.hit) |-> (out_rsp_r.result_id == '0))
    else $error("miss or store response carries a nonzero id");

endmodule

FILE: rtl/core/hashed_memo_cache_direct_mapped_top.sv
// ----------------------------------------------------------------------------
// hashed_memo_cache_direct_mapped_top: direct-mapped memo cache
// Caches successor ids under a (node id, step exponent) key in a table
// indexed by a SplitMix64-style hash of the key.
// ----------------------------------------------------------------------------
// After reset the block first clears the valid flags of all 2**INDEX_BITS
// table entries, one entry per cycle (1024 entries at the default size);
// full stays high during that pass. Afterwards every request is either a
// lookup or a store. The front hashes the key (from_id, step_exp, from_id,
// step_exp) with one shared 32x32 multiplier, three passes per 64-bit product
// and fourteen products per key, and takes the next request only once idle again.
// Hashed requests wait in a two-entry queue; the back end then writes a
// store into the table at once, or reads the table for a lookup and compares
// the key in the following cycle. Each request gives exactly one response, in
// request order: a store answers hit = 0 with result_id = 0, a lookup
// answers the stored id with hit = 1 on a key match and zeros otherwise.
// The response register and the queue let the front keep hashing while a
// response waits to be popped.
// ----------------------------------------------------------------------------
module hashed_memo_cache_direct_mapped_top #(
  parameter int unsigned INDEX_BITS = hmc_pkg::HMC_INDEX_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  hmc_pkg::hmc_req_t in_req,
  output logic              empty,
  input  logic              pop,
  output hmc_pkg::hmc_rsp_t out_rsp
);

  localparam int unsigned Q_WIDTH = $bits(hmc_pkg::hmc_req_t) + INDEX_BITS;

  logic                  front_idle, clearing;
  logic                  fq_push, fq_full, bq_pop, bq_empty;
  hmc_pkg::hmc_req_t     fq_req, bq_req;
  logic [INDEX_BITS-1:0] fq_index, bq_index;
  logic [Q_WIDTH-1:0]    q_wdata, q_rdata;

  // New requests are refused while the hash unit is busy or the table is
  // still being cleared.
  assign full = !front_idle || clearing;

  hmc_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (push && !full),
    .req_in    (in_req),
    .idle      (front_idle),
    .q_push    (fq_push),
    .q_full    (fq_full),
    .q_req     (fq_req),
    .q_index   (fq_index)
  );

  assign q_wdata = {fq_index, fq_req};

  hmc_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (fq_push),
    .q_full  (fq_full),
    .q_wdata (q_wdata),
    .q_pop   (bq_pop),
    .q_empty (bq_empty),
    .q_rdata (q_rdata)
  );

  assign bq_req   = q_rdata[$bits(hmc_pkg::hmc_req_t)-1:0];
  assign bq_index = q_rdata[Q_WIDTH-1:$bits(hmc_pkg::hmc_req_t)];

  hmc_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (bq_empty),
    .q_pop     (bq_pop),
    .q_req     (bq_req),
    .q_index   (bq_index),
    .clearing  (clearing),
    .out_empty (empty),
    .out_pop   (pop),
    .out_rsp   (out_rsp)
  );

endmodule

FILE: dv/hashed_memo_cache_direct_mapped_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_memo_cache_direct_mapped_top_tb: self-checking bench of the memo cache
// Drives lookup and store requests through the push/full queue port and pops
// the responses through empty/pop. A bench-side copy of the hashed table
// predicts each response that a directed row does not give, and the responses are compared in order.
// ----------------------------------------------------------------------------
module hashed_memo_cache_direct_mapped_top_tb;

  localparam int unsigned SLOTS        = 1 << hmc_pkg::HMC_INDEX_BITS;
  localparam logic [62:0] ID_MAX       = 63'h7FFF_FFFF_FFFF_FFFF;
  // Hash constants, 64-bit wrapping arithmetic.
  localparam logic [63:0] MIX_INC      = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL1     = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL2     = 64'h94d0_49bb_1331_11eb;
  localparam logic [63:0] ACC_START    = 64'h243f_6a88_85a3_08d3;
  // Run control. The block takes one request at a time, so the limit
  // leaves several times the slowest legal run, clearing pass included.
  localparam int          CYCLE_LIMIT  = 300_000;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          POOL_SIZE    = 32;
  localparam int          PAIR_COUNT   = 8;
  localparam int          N_DIRECTED   = 17;

  typedef struct packed {
    logic [62:0] id;
    logic [5:0]  ex;
  } memo_key_t;

  // One row of the directed table. When known is set, answer holds the
  // response that can be read straight off the request history; otherwise
  // the predictor supplies it.
  typedef struct packed {
    hmc_pkg::hmc_req_t req;
    logic              known;
    hmc_pkg::hmc_rsp_t answer;
  } directed_row_t;

  logic              clk    = 1'b0;
  logic              rst_n  = 1'b0;
  logic              push   = 1'b0;
  logic              pop    = 1'b0;
  hmc_pkg::hmc_req_t in_req = '0;
  logic              full;
  logic              empty;
  hmc_pkg::hmc_rsp_t out_rsp;

  // Bench copy of the cache table.
  logic        memo_valid   [SLOTS];
  logic [62:0] memo_key_id  [SLOTS];
  logic [5:0]  memo_key_exp [SLOTS];
  logic [62:0] memo_result  [SLOTS];

  hmc_pkg::hmc_rsp_t pending_answers[$];
  memo_key_t   key_pool   [POOL_SIZE];
  memo_key_t   clash_a    [PAIR_COUNT];
  memo_key_t   clash_b    [PAIR_COUNT];

  int          error_count    = 0;
  int          requests_sent  = 0;
  int          cycle_count    = 0;
  int          tx_idle_pct    = 0;
  int          rx_idle_pct    = 0;
  int          holds_asked    = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    // Empty table right after reset: both key extremes miss.
    '{'{hmc_pkg::OP_LOOKUP, 63'd0, 6'd0, 63'd0}, 1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, ID_MAX, 6'd63, ID_MAX}, 1'b1, '{1'b0, 63'd0}},
    // Store the all-ones id under the all-zero key, then read it back.
    '{'{hmc_pkg::OP_STORE, 63'd0, 6'd0, ID_MAX}, 1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, 63'd0, 6'd0, 63'd0}, 1'b1, '{1'b1, ID_MAX}},
    // A stored zero result still reports a hit.
    '{'{hmc_pkg::OP_STORE, ID_MAX, 6'd63, 63'd0}, 1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, ID_MAX, 6'd63, ID_MAX}, 1'b1, '{1'b1, 63'd0}},
    // Keys that were never stored miss whatever their slot holds.
    '{'{hmc_pkg::OP_LOOKUP, 63'd0, 6'd1, 63'd0}, 1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, ID_MAX, 6'd0, 63'd0}, 1'b1, '{1'b0, 63'd0}},
    // Overwrite of an existing key.
    '{'{hmc_pkg::OP_STORE, 63'd0, 6'd0, 63'd5}, 1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, 63'd0, 6'd0, ID_MAX}, 1'b1, '{1'b1, 63'd5}},
    // Alternating bit patterns in every field.
    '{'{hmc_pkg::OP_STORE, 63'h5555_5555_5555_5555, 6'd42, 63'h2AAA_AAAA_AAAA_AAAA},
      1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, 63'h5555_5555_5555_5555, 6'd42, 63'd0}, 1'b0, '0},
    '{'{hmc_pkg::OP_STORE, 63'h2AAA_AAAA_AAAA_AAAA, 6'd21, 63'h5555_5555_5555_5555},
      1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, 63'h2AAA_AAAA_AAAA_AAAA, 6'd21, 63'd0}, 1'b0, '0},
    '{'{hmc_pkg::OP_LOOKUP, 63'h2AAA_AAAA_AAAA_AAAA, 6'd42, 63'd0}, 1'b0, '0},
    '{'{hmc_pkg::OP_STORE, 63'd1, 6'd32, 63'd1}, 1'b1, '{1'b0, 63'd0}},
    '{'{hmc_pkg::OP_LOOKUP, 63'd1, 6'd32, 63'd0}, 1'b0, '0}
  };

  hashed_memo_cache_direct_mapped_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_req  (in_req),
    .empty   (empty),
    .pop     (pop),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Reset is released at a clock edge.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // A hung block or a lost response ends the run here.
  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // SplitMix64 finalizer with its golden-ratio increment.
  function automatic logic [63:0] mix64(input logic [63:0] x);
    logic [63:0] y;
    y = x + MIX_INC;
    y = (y ^ (y >> 30)) * MIX_MUL1;
    y = (y ^ (y >> 27)) * MIX_MUL2;
    return y ^ (y >> 31);
  endfunction

  // Table slot of a key: the words (id, exp, id, exp) are folded into the
  // accumulator one by one, each offset by its position times the increment.
  function automatic int unsigned key_slot(input logic [62:0] id, input logic [5:0] ex);
    logic [63:0] words [4];
    logic [63:0] acc;
    logic [63:0] folded;
    words[0] = {1'b0, id};
    words[1] = {58'd0, ex};
    words[2] = {1'b0, id};
    words[3] = {58'd0, ex};
    acc = ACC_START;
    for (int k = 0; k < 4; k++) begin
      acc ^= mix64(words[k] + MIX_INC * 64'(k + 1));
      acc = (acc * MIX_INC) ^ (acc >> 32);
    end
    folded = mix64(acc);
    return int'(folded[hmc_pkg::HMC_INDEX_BITS-1:0]);
  endfunction

  // Applies one request to the bench table and returns the response the
  // block owes for it.
  function automatic hmc_pkg::hmc_rsp_t memo_predict(input hmc_pkg::hmc_req_t req);
    int unsigned       slot;
    hmc_pkg::hmc_rsp_t rsp;
    slot = key_slot(req.from_id, req.step_exp);
    rsp  = '0;
    if (req.operation == hmc_pkg::OP_STORE) begin
      memo_valid[slot]   = 1'b1;
      memo_key_id[slot]  = req.from_id;
      memo_key_exp[slot] = req.step_exp;
      memo_result[slot]  = req.to_id;
    end else if (memo_valid[slot] && memo_key_id[slot] == req.from_id &&
                 memo_key_exp[slot] == req.step_exp) begin
      rsp.hit       = 1'b1;
      rsp.result_id = memo_result[slot];
    end
    return rsp;
  endfunction

  // Random id, with the extremes weighted up.
  function automatic logic [62:0] rand_id();
    case ($urandom_range(15))
      0:       return '0;
      1:       return ID_MAX;
      default: return 63'({$urandom, $urandom});
    endcase
  endfunction

  function automatic hmc_pkg::hmc_req_t make_req(input logic op, input memo_key_t k,
                                                 input logic [62:0] to);
    hmc_pkg::hmc_req_t req;
    req.operation = op;
    req.from_id   = k.id;
    req.step_exp  = k.ex;
    req.to_id     = to;
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Presents one request and holds it until the block takes it. The sender
  // may first idle for a few cycles. Push is left high afterwards, so back to
  // back requests never drop it; idling is what lowers it.
  task automatic offer_request(input hmc_pkg::hmc_req_t req, input logic known,
                               input hmc_pkg::hmc_rsp_t answer);
    hmc_pkg::hmc_rsp_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (full !== 1'b0);
    // The request was taken at this edge; the table copy moves on now.
    predicted = memo_predict(req);
    pending_answers.push_back(known ? answer : predicted);
    requests_sent++;
  endtask

  // Random traffic. Most of it is keyed on a small pool so that stores are
  // later found again, or runs stores and lookups on keys that share a slot so
  // entries get evicted. The rest is fully random noise.
  task automatic run_random_traffic(input int n_items);
    int        stop_at;
    int        p;
    memo_key_t k;
    memo_key_t c;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          k = key_pool[$urandom_range(POOL_SIZE - 1)];
          offer_request(make_req(($urandom_range(99) < 40) ? hmc_pkg::OP_STORE :
                                 hmc_pkg::OP_LOOKUP, k, rand_id()), 1'b0, '0);
        end
        4, 5: begin
          p = $urandom_range(PAIR_COUNT - 1);
          k = clash_a[p];
          c = clash_b[p];
          offer_request(make_req(hmc_pkg::OP_STORE,  k, rand_id()), 1'b0, '0);
          offer_request(make_req(hmc_pkg::OP_LOOKUP, k, rand_id()), 1'b0, '0);
          offer_request(make_req(hmc_pkg::OP_LOOKUP, c, rand_id()), 1'b0, '0);
          offer_request(make_req(hmc_pkg::OP_STORE,  c, rand_id()), 1'b0, '0);
          offer_request(make_req(hmc_pkg::OP_LOOKUP, k, rand_id()), 1'b0, '0);
          offer_request(make_req(hmc_pkg::OP_LOOKUP, c, rand_id()), 1'b0, '0);
        end
        6: begin
          // A stored zero must come back as a hit with a zero id.
          k = key_pool[$urandom_range(POOL_SIZE - 1)];
          offer_request(make_req(hmc_pkg::OP_STORE,  k, 63'd0), 1'b0, '0);
          offer_request(make_req(hmc_pkg::OP_LOOKUP, k, rand_id()), 1'b0, '0);
        end
        default: begin
          k.id = rand_id();
          k.ex = 6'($urandom_range(63));
          offer_request(make_req(1'($urandom_range(1)), k, rand_id()), 1'b0, '0);
        end
      endcase
    end
  endtask

  // Response side: checks every popped response against the oldest
  // prediction, then decides the pop for the next cycle. A requested
  // hold-off keeps pop low for a long stretch so the block fills up.
  initial begin
    int                hold_left;
    int                holds_done;
    hmc_pkg::hmc_rsp_t want;
    hold_left  = 0;
    holds_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && empty === 1'b0) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("response with none pending: hit=%0b id=%h",
                                    out_rsp.hit, out_rsp.result_id));
        end else begin
          want = pending_answers.pop_front();
          if (out_rsp.hit !== want.hit) begin
            report_mismatch($sformatf("hit %0b, predicted %0b", out_rsp.hit, want.hit));
          end
          if (out_rsp.result_id !== want.result_id) begin
            report_mismatch($sformatf("result_id %h, predicted %h",
                                      out_rsp.result_id, want.result_id));
          end
        end
      end
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Request side and run sequencing.
  initial begin
    int          found;
    int unsigned slot_a;
    memo_key_t   ka;
    memo_key_t   kb;

    for (int i = 0; i < SLOTS; i++) begin
      memo_valid[i] = 1'b0;
    end

    // Key pool for the random part.
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i].id = rand_id();
      key_pool[i].ex = 6'($urandom_range(63));
    end

    // Pairs of distinct keys that land in the same slot. Even pairs differ
    // only in the exponent, odd pairs only in the id, so each half of the
    // key compare is exercised on its own.
    for (int p = 0; p < PAIR_COUNT; p++) begin
      found = 0;
      while (!found) begin
        ka.id  = rand_id();
        ka.ex  = 6'($urandom_range(63));
        slot_a = key_slot(ka.id, ka.ex);
        kb     = ka;
        if (p % 2 == 0) begin
          for (int e = 0; e < 64; e++) begin
            if (!found && 6'(e) != ka.ex && key_slot(ka.id, 6'(e)) == slot_a) begin
              kb.ex = 6'(e);
              found = 1;
            end
          end
        end else begin
          for (int t = 0; t < 8 * SLOTS && !found; t++) begin
            kb.id = 63'({$urandom, $urandom});
            if (kb.id != ka.id && key_slot(kb.id, ka.ex) == slot_a) begin
              found = 1;
            end
          end
        end
      end
      clash_a[p] = ka;
      clash_b[p] = kb;
    end

    wait (rst_n === 1'b1);
    @(posedge clk);

    // First phase: the sender idles a little, the receiver a lot.
    tx_idle_pct = 27;
    rx_idle_pct = 68;
    for (int r = 0; r < N_DIRECTED; r++) begin
      offer_request(directed_rows[r].req, directed_rows[r].known, directed_rows[r].answer);
    end
    holds_asked++;
    run_random_traffic(240);

    // Second phase: the roles are swapped.
    tx_idle_pct = 68;
    rx_idle_pct = 27;
    run_random_traffic(230);

    // Last phase: nobody idles, and one long receiver hold-off lets the
    // block back up until full stalls the sender.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_asked++;
    run_random_traffic(230);

    push <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // Any stray response in this window is flagged by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
